/* design/bfdh_pkg.sv */
// shared constants and the fnv-1a byte step for the bloom filter engine
package bfdh_pkg;

  localparam int DEF_MAX_BITS   = 65536;
  localparam int DEF_MAX_HASHES = 16;

  // filter memory row width, bit index within a row takes ROW_BIT_W bits
  localparam int ROW_W     = 32;
  localparam int ROW_BIT_W = 5;

  localparam int HASH_W       = 64;
  localparam int BITS_CFG_W   = 17;
  localparam int HASHES_CFG_W = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 17;
  localparam int COUNT_W      = 32;

  localparam logic [BITS_CFG_W-1:0]   BITS_RESET   = 17'd65536;
  localparam logic [HASHES_CFG_W-1:0] HASHES_RESET = 5'd7;

  localparam logic [CFG_IDX_W-1:0] REG_BITS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT  = 2'd1;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [HASH_W-1:0] FNV_OFFSET      = 64'hcbf29ce484222325;
  localparam logic [HASH_W-1:0] SEED_ONE        = 64'h243f6a8885a308d3;
  localparam logic [HASH_W-1:0] SEED_TWO        = 64'h9e3779b97f4a7c15;
  localparam logic [HASH_W-1:0] SECOND_FALLBACK = 64'h27d4eb2f165667c5;
  localparam logic [HASH_W-1:0] HASH_ONE_INIT   = FNV_OFFSET ^ SEED_ONE;
  localparam logic [HASH_W-1:0] HASH_TWO_INIT   = FNV_OFFSET ^ SEED_TWO;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // (h ^ b) * 0x100000001b3 as shifts and adds
  function automatic logic [HASH_W-1:0] fnv_step(logic [HASH_W-1:0] h, logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8);
  endfunction

endpackage

/* design/bloom_filter_fnv_double_hash.sv */
// bloom filter engine: fnv-1a double hashing over a row-organized bit memory
// a key byte that is not last is folded into both hashes when taken; a last byte starts the
// remainder phase (bit-serial mod unit, 3 lanes), then each probe does a memory read, then a check or
// read-modify-write, and the result is loaded into the output register once out_stall allows
// a clear op sweeps one memory row per cycle over all MAX_BITS/32 rows (2048 at default)
// after reset the same clearing sweep runs while in_stall stays high; config is taken anytime
module bloom_filter_fnv_double_hash #(
  parameter int MAX_BITS   = bfdh_pkg::DEF_MAX_BITS,
  parameter int MAX_HASHES = bfdh_pkg::DEF_MAX_HASHES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfdh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_op,
  input  logic [7:0]                      in_key_byte,
  input  logic                            in_byte_valid,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_done_op,
  output logic                            out_maybe_present,
  output logic [bfdh_pkg::COUNT_W-1:0]    out_added_total
);
  import bfdh_pkg::*;

  localparam int M_W    = $clog2(MAX_BITS + 1);
  localparam int K_W    = $clog2(MAX_HASHES + 1);
  localparam int ROWS   = (MAX_BITS + ROW_W - 1) / ROW_W;
  localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W  = ADDR_W + ROW_BIT_W;
  localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(ROWS - 1);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_MOD, S_RD, S_CHK, S_FIN} state_t;

  state_t                  state_r;
  logic [BITS_CFG_W-1:0]   bits_cfg_r;
  logic [HASHES_CFG_W-1:0] hashes_cfg_r;
  logic [HASH_W-1:0]       h1_r, h2_r, sh1_r, sh2_r;
  logic [M_W-1:0]          m_r, res_r, dres_r, wres_r;
  logic [K_W-1:0]          k_r, pc_r;
  logic [5:0]              mod_cnt_r;
  logic [ADDR_W-1:0]       clr_row_r;
  logic                    clr_reply_r;
  logic [1:0]              op_r;
  logic                    all_set_r;
  logic [COUNT_W-1:0]      count_r;
  logic                    out_valid_r;
  logic [1:0]              out_done_op_r;
  logic                    out_maybe_present_r;
  logic [COUNT_W-1:0]      out_added_total_r;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rd_data_r;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [ROW_W-1:0] mem_wd;

  logic [M_W-1:0]       m_eff;
  logic [K_W-1:0]       k_eff;
  logic [HASH_W-1:0]    h1_fold, h2_fold, h2_probe;
  logic [IDX_W-1:0]     idx;
  logic [ADDR_W-1:0]    probe_row;
  logic [ROW_BIT_W-1:0] probe_bit;
  logic [ROW_W-1:0]     probe_mask;
  logic                 bit_hit;
  logic [HASH_W:0]      sum_ext;
  logic [M_W:0]         t1, t2w, t3w;
  logic [M_W-1:0]       t2, res_next;
  logic [M_W-1:0]       r1_step, r2_step, rw_step;
  logic                 in_take;

  function automatic logic [M_W-1:0] mod_step(logic [M_W-1:0] r, logic b, logic [M_W-1:0] m);
    logic [M_W:0] x;
    x = {r, b};
    if (x >= {1'b0, m}) x = x - {1'b0, m};
    return x[M_W-1:0];
  endfunction

  // effective modulus and probe count, zero means one, large values saturate
  always_comb begin
    if (bits_cfg_r == '0) begin
      m_eff = M_W'(1);
    end else if (32'(bits_cfg_r) > 32'(MAX_BITS)) begin
      m_eff = M_W'(MAX_BITS);
    end else begin
      m_eff = M_W'(bits_cfg_r);
    end
    if (hashes_cfg_r == '0) begin
      k_eff = K_W'(1);
    end else if (32'(hashes_cfg_r) > 32'(MAX_HASHES)) begin
      k_eff = K_W'(MAX_HASHES);
    end else begin
      k_eff = K_W'(hashes_cfg_r);
    end
  end

  assign h1_fold  = in_byte_valid ? fnv_step(h1_r, in_key_byte) : h1_r;
  assign h2_fold  = in_byte_valid ? fnv_step(h2_r, in_key_byte) : h2_r;
  assign h2_probe = (h2_fold == '0) ? SECOND_FALLBACK : h2_fold;

  assign r1_step = mod_step(res_r, sh1_r[HASH_W-1], m_r);
  assign r2_step = mod_step(dres_r, sh2_r[HASH_W-1], m_r);
  assign rw_step = mod_step(wres_r, 1'b0, m_r);

  assign idx        = IDX_W'(res_r);
  assign probe_row  = idx[IDX_W-1:ROW_BIT_W];
  assign probe_bit  = idx[ROW_BIT_W-1:0];
  assign probe_mask = ROW_W'(1) << probe_bit;
  assign bit_hit    = rd_data_r[probe_bit];

  // next index: residue tracks the 64-bit wrapping sum, a carry removes 2^64 mod m
  always_comb begin
    sum_ext = {1'b0, h1_r} + {1'b0, h2_r};
    t1      = {1'b0, res_r} + {1'b0, dres_r};
    t2w     = (t1 >= {1'b0, m_r}) ? t1 - {1'b0, m_r} : t1;
    t2      = t2w[M_W-1:0];
    if (!sum_ext[HASH_W]) begin
      t3w = {1'b0, t2};
    end else if (t2 >= wres_r) begin
      t3w = {1'b0, t2} - {1'b0, wres_r};
    end else begin
      t3w = {1'b0, t2} + {1'b0, m_r} - {1'b0, wres_r};
    end
    res_next = t3w[M_W-1:0];
  end

  assign mem_we = (state_r == S_CLR) || (state_r == S_CHK && op_r == OP_ADD);
  assign mem_wa = (state_r == S_CLR) ? clr_row_r : probe_row;
  assign mem_wd = (state_r == S_CLR) ? '0 : (rd_data_r | probe_mask);
  assign mem_ra = probe_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  assign cfg_ready         = 1'b1;
  assign in_stall          = (state_r != S_IDLE);
  assign in_take           = in_valid && (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_done_op       = out_done_op_r;
  assign out_maybe_present = out_maybe_present_r;
  assign out_added_total   = out_added_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      bits_cfg_r   <= BITS_RESET;
      hashes_cfg_r <= HASHES_RESET;
      h1_r         <= HASH_ONE_INIT;
      h2_r         <= HASH_TWO_INIT;
      clr_row_r    <= '0;
      clr_reply_r  <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BITS_IN_USE) begin
          bits_cfg_r <= cfg_data[BITS_CFG_W-1:0];
        end else if (cfg_index == REG_HASH_COUNT) begin
          hashes_cfg_r <= cfg_data[HASHES_CFG_W-1:0];
        end
      end

      // a finishing item reloads the output register on its own
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLR: begin
          clr_row_r <= clr_row_r + ADDR_W'(1);
          if (clr_row_r == LAST_ROW) begin
            state_r <= clr_reply_r ? S_FIN : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            if (in_op == OP_CLEAR) begin
              h1_r        <= HASH_ONE_INIT;
              h2_r        <= HASH_TWO_INIT;
              count_r     <= '0;
              clr_row_r   <= '0;
              clr_reply_r <= 1'b1;
              op_r        <= OP_CLEAR;
              state_r     <= S_CLR;
            end else if (in_op == OP_ADD || in_op == OP_QUERY) begin
              if (in_last_byte) begin
                h1_r      <= h1_fold;
                h2_r      <= h2_probe;
                sh1_r     <= h1_fold;
                sh2_r     <= h2_probe;
                m_r       <= m_eff;
                k_r       <= k_eff;
                res_r     <= '0;
                dres_r    <= '0;
                wres_r    <= (m_eff == M_W'(1)) ? '0 : M_W'(1);
                mod_cnt_r <= '0;
                pc_r      <= '0;
                all_set_r <= 1'b1;
                op_r      <= in_op;
                state_r   <= S_MOD;
              end else begin
                h1_r <= h1_fold;
                h2_r <= h2_fold;
              end
            end
          end
        end
        S_MOD: begin
          res_r     <= r1_step;
          dres_r    <= r2_step;
          wres_r    <= rw_step;
          sh1_r     <= sh1_r << 1;
          sh2_r     <= sh2_r << 1;
          mod_cnt_r <= mod_cnt_r + 6'd1;
          if (mod_cnt_r == 6'd63) begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (op_r == OP_QUERY && !bit_hit) begin
            all_set_r <= 1'b0;
          end
          if (pc_r == k_r - K_W'(1)) begin
            state_r <= S_FIN;
          end else begin
            pc_r    <= pc_r + K_W'(1);
            h1_r    <= sum_ext[HASH_W-1:0];
            res_r   <= res_next;
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r         <= 1'b1;
            out_done_op_r       <= op_r;
            out_maybe_present_r <= (op_r == OP_QUERY) && all_set_r;
            if (op_r == OP_ADD && count_r != COUNT_MAX) begin
              count_r           <= count_r + COUNT_W'(1);
              out_added_total_r <= count_r + COUNT_W'(1);
            end else begin
              out_added_total_r <= count_r;
            end
            h1_r        <= HASH_ONE_INIT;
            h2_r        <= HASH_TWO_INIT;
            clr_reply_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // residues handed to the probe loop stay below the modulus
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_CHK) |-> (res_r < m_r && dres_r < m_r && wres_r < m_r))
    else $error("probe residue out of range");

  // a query never writes the filter memory
  a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && op_r == OP_QUERY) |-> !mem_we)
    else $error("memory written during query");

  // a positive answer only comes with a query result
  a_present_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_maybe_present_r) |-> (out_done_op_r == OP_QUERY))
    else $error("maybe_present set on non-query result");

  // the remainder unit always runs its full count before probing
  a_mod_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && mod_cnt_r != 6'd63) |=> (state_r == S_MOD))
    else $error("remainder unit left early");

  // the counter changes only on a finished add or a clear
  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> ($past(state_r) == S_FIN || $past(in_take)))
    else $error("added count changed unexpectedly");

endmodule
